// File: sv/alc_pkg.sv
// ----------------------------------------------------------------------------
// alc_pkg: shared types and constants for the ambient light lux datapath
// Beat types, calibration coefficients, status codes and the power-law table.
// ----------------------------------------------------------------------------
package alc_pkg;

  localparam int POW_TABLE_DEPTH_DEF = 64;
  localparam int LUX_FRAC_BITS_DEF   = 8;

  localparam logic [7:0] REG_INT_TIME = 8'd0;
  localparam logic [7:0] REG_GAIN     = 8'd1;

  localparam logic [1:0] IT_13MS  = 2'd0;
  localparam logic [1:0] IT_101MS = 2'd1;
  localparam logic [1:0] IT_402MS = 2'd2;

  localparam logic [2:0] ST_BAND0 = 3'd0;
  localparam logic [2:0] ST_BAND1 = 3'd1;
  localparam logic [2:0] ST_BAND2 = 3'd2;
  localparam logic [2:0] ST_BAND3 = 3'd3;
  localparam logic [2:0] ST_RANGE = 3'd4;
  localparam logic [2:0] ST_SAT   = 3'd5;
  localparam logic [2:0] ST_DARK  = 3'd6;

  localparam logic [15:0] LIMIT_13MS  = 16'd5047;
  localparam logic [15:0] LIMIT_101MS = 16'd37177;
  localparam logic [15:0] LIMIT_402MS = 16'd65535;

  localparam logic [20:0] SCALE_13MS  = 21'd1927529;
  localparam logic [20:0] SCALE_101MS = 21'd260063;
  localparam logic [20:0] SCALE_402MS = 21'd65536;

  localparam logic [19:0] K0_BAND0 = 20'd528482;
  localparam logic [19:0] K1_BAND0 = 20'd994889;
  localparam logic [18:0] K0_BAND1 = 19'd375810;
  localparam logic [18:0] K1_BAND1 = 19'd520094;
  localparam logic [18:0] K0_BAND2 = 19'd263402;
  localparam logic [18:0] K1_BAND2 = 19'd301990;
  localparam logic [18:0] K0_BAND3 = 19'd56707;
  localparam logic [18:0] K1_BAND3 = 19'd43621;

  localparam logic [27:0] LUX_MAX = 28'hFFFFFFF;

  typedef struct packed {
    logic [15:0] broadband_count;
    logic [15:0] infrared_count;
  } alc_in_t;

  typedef struct packed {
    logic [27:0] lux_value;
    logic [15:0] ratio_q16;
    logic [2:0]  status;
  } alc_out_t;

  typedef struct packed {
    logic [15:0] c0;
    logic [15:0] c1;
    logic [2:0]  status;
    logic        ratio_ffff;
    logic        ratio_zero;
  } alc_carry_t;

  // Largest y with y^5 * depth^7 <= i^7 * 2^80, i.e. floor(65536*(i/depth)^1.4).
  function automatic logic [16:0] pow_entry(input int i, input int depth);
    logic [191:0] lhs;
    logic [191:0] rhs;
    logic [17:0]  lo;
    logic [17:0]  hi;
    logic [17:0]  mid;
    int           k;
    int           n;
    lo = 18'd0;
    hi = 18'd65537;
    for (n = 0; n < 20; n++) begin
      if ((hi - lo) > 18'd1) begin
        mid = (lo + hi) >> 1;
        lhs = 192'd1;
        rhs = 192'd1;
        for (k = 0; k < 5; k++) lhs = lhs * 192'(mid);
        for (k = 0; k < 7; k++) lhs = lhs * 192'(depth);
        for (k = 0; k < 7; k++) rhs = rhs * 192'(i);
        rhs = rhs << 80;
        if (lhs <= rhs) begin
          lo = mid;
        end else begin
          hi = mid;
        end
      end
    end
    return lo[16:0];
  endfunction

endpackage

// File: sv/alc_div_cell.sv
// ----------------------------------------------------------------------------
// alc_div_cell: one restoring division cell
// Produces one quotient bit of the infrared over broadband ratio per cell.
// ----------------------------------------------------------------------------
module alc_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                v_i,
  input  alc_pkg::alc_carry_t carry_i,
  input  logic [15:0]         rem_i,
  input  logic [15:0]         quo_i,
  output logic                v_o,
  output alc_pkg::alc_carry_t carry_o,
  output logic [15:0]         rem_o,
  output logic [15:0]         quo_o
);

  logic                v_r;
  alc_pkg::alc_carry_t carry_r;
  logic [15:0]         rem_r;
  logic [15:0]         quo_r;
  logic [16:0]         shl;
  logic [16:0]         dif;
  logic                ge;

  always_comb begin
    shl = {rem_i, 1'b0};
    ge  = shl >= {1'b0, carry_i.c0};
    dif = shl - {1'b0, carry_i.c0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_i;
    end
    carry_r <= carry_i;
    rem_r   <= ge ? dif[15:0] : shl[15:0];
    quo_r   <= {quo_i[14:0], ge};
  end

  assign v_o     = v_r;
  assign carry_o = carry_r;
  assign rem_o   = rem_r;
  assign quo_o   = quo_r;

endmodule

// File: sv/alc_post.sv
// ----------------------------------------------------------------------------
// alc_post: lux formula pipeline
// Power-law lookup, band formulas, clamping, scaling and saturation.
// ----------------------------------------------------------------------------
module alc_post #(
  parameter int POW_TABLE_DEPTH = alc_pkg::POW_TABLE_DEPTH_DEF,
  parameter int LUX_FRAC_BITS   = alc_pkg::LUX_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                v_i,
  input  alc_pkg::alc_carry_t carry_i,
  input  logic [15:0]         quo_i,
  input  logic [1:0]          int_time,
  input  logic                hi_gain,
  output logic                v_o,
  output alc_pkg::alc_out_t   out_o
);

  localparam int DW     = $clog2(POW_TABLE_DEPTH + 1);
  localparam int NST    = 8;
  localparam int SHIFT  = 40 - LUX_FRAC_BITS;

  typedef struct packed {
    logic [15:0] ratio;
    logic [2:0]  status;
  } tag_t;

  logic [16:0] pow_tab [0:POW_TABLE_DEPTH];

  for (genvar g = 0; g <= POW_TABLE_DEPTH; g++) begin : g_tab
    localparam logic [16:0] TV = alc_pkg::pow_entry(g, POW_TABLE_DEPTH);
    assign pow_tab[g] = TV;
  end

  logic [NST-1:0] v_r;
  tag_t           tag_r [1:NST-1];

  logic [15:0]        ratio_nxt;
  logic [16+DW-1:0]   s_nxt;
  logic [DW-1:0]      idx;
  logic [DW-1:0]      idx1;
  logic [18:0]        ka_nxt;
  logic [18:0]        kb_nxt;

  logic [16:0]        a1_r;
  logic [16:0]        b1_r;
  logic [15:0]        f1_r;
  logic [34:0]        pa1_r;
  logic [34:0]        pb1_r;
  logic [15:0]        c0_1_r;

  logic [16:0]        a2_r;
  logic [32:0]        diff2_r;
  logic signed [38:0] db2_r;
  logic [15:0]        c0_2_r;

  logic [16:0]        p3_r;
  logic signed [38:0] db3_r;
  logic [15:0]        c0_3_r;

  logic [36:0]        m4_r;
  logic signed [38:0] db4_r;
  logic [15:0]        c0_4_r;

  logic signed [21:0] k5;
  logic signed [38:0] d05_r;
  logic signed [38:0] db5_r;

  logic signed [38:0] dsel;
  logic [35:0]        du6_r;

  logic [20:0]        scale;
  logic [38:0]        plo7_r;
  logic [38:0]        phi7_r;

  logic [56:0]        tot;
  logic [60:0]        gsc;
  logic [60:0]        shr;
  logic [27:0]        lux_nxt;
  alc_pkg::alc_out_t  out_r;

  always_comb begin
    if (carry_i.ratio_zero) begin
      ratio_nxt = 16'd0;
    end else if (carry_i.ratio_ffff) begin
      ratio_nxt = 16'hFFFF;
    end else begin
      ratio_nxt = quo_i;
    end
    s_nxt = (16+DW)'(quo_i) * (16+DW)'(POW_TABLE_DEPTH);
    idx   = s_nxt[16+DW-1:16];
    idx1  = idx + DW'(1);
    case (carry_i.status)
      alc_pkg::ST_BAND1: begin
        ka_nxt = alc_pkg::K0_BAND1;
        kb_nxt = alc_pkg::K1_BAND1;
      end
      alc_pkg::ST_BAND2: begin
        ka_nxt = alc_pkg::K0_BAND2;
        kb_nxt = alc_pkg::K1_BAND2;
      end
      alc_pkg::ST_BAND3: begin
        ka_nxt = alc_pkg::K0_BAND3;
        kb_nxt = alc_pkg::K1_BAND3;
      end
      default: begin
        ka_nxt = 19'd0;
        kb_nxt = 19'd0;
      end
    endcase
  end

  always_comb begin
    k5   = 22'sd0 + $signed({2'b00, alc_pkg::K0_BAND0}) - $signed({1'b0, m4_r[36:16]});
    dsel = (tag_r[5].status == alc_pkg::ST_BAND0) ? d05_r : db5_r;
    case (int_time)
      alc_pkg::IT_13MS:  scale = alc_pkg::SCALE_13MS;
      alc_pkg::IT_101MS: scale = alc_pkg::SCALE_101MS;
      default:           scale = alc_pkg::SCALE_402MS;
    endcase
    tot = {phi7_r[38:0], 18'd0} + 57'(plo7_r);
    gsc = hi_gain ? 61'(tot) : {tot, 4'd0};
    shr = gsc >> SHIFT;
    lux_nxt = (shr > 61'(alc_pkg::LUX_MAX)) ? alc_pkg::LUX_MAX : shr[27:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[NST-2:0], v_i};
    end
    tag_r[1] <= '{ratio: ratio_nxt, status: carry_i.status};
    for (int j = 2; j < NST; j++) tag_r[j] <= tag_r[j-1];

    a1_r   <= pow_tab[idx];
    b1_r   <= pow_tab[idx1];
    f1_r   <= s_nxt[15:0];
    pa1_r  <= 35'(ka_nxt) * 35'(carry_i.c0);
    pb1_r  <= 35'(kb_nxt) * 35'(carry_i.c1);
    c0_1_r <= carry_i.c0;

    a2_r    <= a1_r;
    diff2_r <= 33'(b1_r - a1_r) * 33'(f1_r);
    db2_r   <= $signed({4'd0, pa1_r}) - $signed({4'd0, pb1_r});
    c0_2_r  <= c0_1_r;

    p3_r   <= a2_r + diff2_r[32:16];
    db3_r  <= db2_r;
    c0_3_r <= c0_2_r;

    m4_r   <= 37'(alc_pkg::K1_BAND0) * 37'(p3_r);
    db4_r  <= db3_r;
    c0_4_r <= c0_3_r;

    d05_r <= 39'(k5) * $signed({23'd0, c0_4_r});
    db5_r <= db4_r;

    if (dsel < 0 || tag_r[5].status > alc_pkg::ST_BAND3) begin
      du6_r <= 36'd0;
    end else begin
      du6_r <= dsel[35:0];
    end

    plo7_r <= 39'(du6_r[17:0]) * 39'(scale);
    phi7_r <= 39'(du6_r[35:18]) * 39'(scale);

    out_r.lux_value <= lux_nxt;
    out_r.ratio_q16 <= tag_r[7].ratio;
    out_r.status    <= tag_r[7].status;
  end

  assign v_o   = v_r[NST-1];
  assign out_o = out_r;

endmodule

// File: sv/ambient_light_lux_calc.sv
// ----------------------------------------------------------------------------
// ambient_light_lux_calc: two-channel ambient light lux calculator
// Turns broadband and infrared photodiode counts into lux, ratio and status.
// ----------------------------------------------------------------------------
// A count pair is taken in every cycle (busy stays low) and its result appears
// on out_data with out_strobe high for one cycle, after it has passed the row
// of division cells, one quotient bit per cell, and then the lux formula
// pipeline. The receiver cannot stall, so each result must be captured in
// the cycle it is shown. Configuration takes effect on the next beat and
// should be written while no beat is in flight.
module ambient_light_lux_calc #(
  parameter int POW_TABLE_DEPTH = alc_pkg::POW_TABLE_DEPTH_DEF,
  parameter int LUX_FRAC_BITS   = alc_pkg::LUX_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  alc_pkg::alc_in_t  in_data,
  output logic              out_strobe,
  output alc_pkg::alc_out_t out_data,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_index,
  input  logic [1:0]        cfg_wdata
);

  localparam int NCELL = 16;

  logic [1:0]  int_time_r;
  logic        hi_gain_r;

  logic                v_c     [0:NCELL];
  alc_pkg::alc_carry_t carry_c [0:NCELL];
  logic [15:0]         rem_c   [0:NCELL];
  logic [15:0]         quo_c   [0:NCELL];

  logic [15:0] c0;
  logic [15:0] c1;
  logic [15:0] limit;
  logic [23:0] p100;
  logic [23:0] p52;
  logic [23:0] p65;
  logic [23:0] p80;
  logic [23:0] p130;
  alc_pkg::alc_carry_t carry0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_time_r <= alc_pkg::IT_402MS;
      hi_gain_r  <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == alc_pkg::REG_INT_TIME) begin
        int_time_r <= cfg_wdata;
      end else if (cfg_index == alc_pkg::REG_GAIN) begin
        hi_gain_r <= cfg_wdata[0];
      end
    end
  end

  always_comb begin
    c0 = in_data.broadband_count;
    c1 = in_data.infrared_count;
    case (int_time_r)
      alc_pkg::IT_13MS:  limit = alc_pkg::LIMIT_13MS;
      alc_pkg::IT_101MS: limit = alc_pkg::LIMIT_101MS;
      default:           limit = alc_pkg::LIMIT_402MS;
    endcase
    p100 = 24'(c1) * 24'd100;
    p52  = 24'(c0) * 24'd52;
    p65  = 24'(c0) * 24'd65;
    p80  = 24'(c0) * 24'd80;
    p130 = 24'(c0) * 24'd130;
    carry0.c0         = c0;
    carry0.c1         = c1;
    carry0.ratio_zero = 1'b0;
    carry0.ratio_ffff = (c1 >= c0);
    if (c0 >= limit || c1 >= limit) begin
      carry0.status     = alc_pkg::ST_SAT;
      carry0.ratio_zero = 1'b1;
    end else if (c0 == 16'd0) begin
      if (c1 == 16'd0) begin
        carry0.status     = alc_pkg::ST_DARK;
        carry0.ratio_zero = 1'b1;
      end else begin
        carry0.status = alc_pkg::ST_RANGE;
      end
    end else if (p100 <= p52) begin
      carry0.status = alc_pkg::ST_BAND0;
    end else if (p100 <= p65) begin
      carry0.status = alc_pkg::ST_BAND1;
    end else if (p100 <= p80) begin
      carry0.status = alc_pkg::ST_BAND2;
    end else if (p100 <= p130) begin
      carry0.status = alc_pkg::ST_BAND3;
    end else begin
      carry0.status = alc_pkg::ST_RANGE;
    end
  end

  assign v_c[0]     = start;
  assign carry_c[0] = carry0;
  assign rem_c[0]   = c1;
  assign quo_c[0]   = 16'd0;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    alc_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .v_i     (v_c[g]),
      .carry_i (carry_c[g]),
      .rem_i   (rem_c[g]),
      .quo_i   (quo_c[g]),
      .v_o     (v_c[g+1]),
      .carry_o (carry_c[g+1]),
      .rem_o   (rem_c[g+1]),
      .quo_o   (quo_c[g+1])
    );
  end

  alc_post #(
    .POW_TABLE_DEPTH (POW_TABLE_DEPTH),
    .LUX_FRAC_BITS   (LUX_FRAC_BITS)
  ) u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .v_i      (v_c[NCELL]),
    .carry_i  (carry_c[NCELL]),
    .quo_i    (quo_c[NCELL]),
    .int_time (int_time_r),
    .hi_gain  (hi_gain_r),
    .v_o      (out_strobe),
    .out_o    (out_data)
  );

  assign busy = 1'b0;

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for ambient_light_lux_calc
// Drives count pairs in random bursts across every integration time and gain
// setting. Each beat is predicted by an independent lux model, and each
// strobed result is compared field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  import alc_pkg::*;

  localparam int PIPE_DRAIN = 40;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  alc_in_t  in_data;
  logic     out_strobe;
  alc_out_t out_data;
  logic     cfg_we;
  logic [7:0] cfg_index;
  logic [1:0] cfg_wdata;

  alc_out_t   lux_expected_q[$];
  logic [16:0] pow_lut[0:POW_TABLE_DEPTH_DEF];
  logic [1:0] int_time_sel;
  logic       gain_is_high;
  int         fail_count;
  int         beats_sent;
  int         results_seen;
  int         status_hits[0:7];

  ambient_light_lux_calc u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic bit pow_fits(longint unsigned y, int i);
    logic [127:0] lhs;
    logic [127:0] rhs;
    lhs = 128'd1;
    rhs = 128'd1;
    for (int k = 0; k < 5; k++) lhs = lhs * 128'(y);
    for (int k = 0; k < 7; k++) rhs = rhs * 128'(i);
    rhs = rhs << 38;
    return lhs <= rhs;
  endfunction

  task automatic fill_pow_lut();
    longint unsigned y;
    for (int i = 0; i <= POW_TABLE_DEPTH_DEF; i++) begin
      y = longint'($floor(65536.0 * $pow(real'(i) / POW_TABLE_DEPTH_DEF, 1.4)));
      while (y > 0 && !pow_fits(y, i)) y--;
      while (y < 65536 && pow_fits(y + 1, i)) y++;
      pow_lut[i] = 17'(y);
    end
  endtask

  function automatic longint unsigned ratio_pow14(longint unsigned ratio);
    longint unsigned s;
    longint unsigned idx;
    longint unsigned frac;
    longint unsigned a;
    longint unsigned b;
    s = ratio * POW_TABLE_DEPTH_DEF;
    idx = s >> 16;
    frac = s & 64'hFFFF;
    if (idx >= POW_TABLE_DEPTH_DEF) return pow_lut[POW_TABLE_DEPTH_DEF];
    a = pow_lut[idx];
    b = pow_lut[idx + 1];
    if (b < a) b = a;
    return a + (((b - a) * frac) >> 16);
  endfunction

  function automatic alc_out_t compute_lux(logic [15:0] c0, logic [15:0] c1);
    alc_out_t r;
    longint unsigned limit;
    longint unsigned scale;
    longint unsigned ratio;
    longint unsigned lux;
    longint d;
    longint k;
    r = '0;
    case (int_time_sel)
      IT_13MS: begin
        limit = LIMIT_13MS;
        scale = SCALE_13MS;
      end
      IT_101MS: begin
        limit = LIMIT_101MS;
        scale = SCALE_101MS;
      end
      default: begin
        limit = LIMIT_402MS;
        scale = SCALE_402MS;
      end
    endcase
    if (c0 >= limit || c1 >= limit) begin
      r.status = ST_SAT;
      return r;
    end
    if (c0 == 0) begin
      if (c1 == 0) begin
        r.status = ST_DARK;
      end else begin
        r.ratio_q16 = 16'hFFFF;
        r.status = ST_RANGE;
      end
      return r;
    end
    ratio = (longint'(c1) << 16) / c0;
    if (ratio > 64'hFFFF) ratio = 64'hFFFF;
    r.ratio_q16 = ratio[15:0];
    if (100 * longint'(c1) <= 52 * longint'(c0)) begin
      k = longint'(K0_BAND0) - longint'((longint'(K1_BAND0) * ratio_pow14(ratio)) >> 16);
      d = k * longint'(c0);
      r.status = ST_BAND0;
    end else if (100 * longint'(c1) <= 65 * longint'(c0)) begin
      d = longint'(K0_BAND1) * c0 - longint'(K1_BAND1) * c1;
      r.status = ST_BAND1;
    end else if (100 * longint'(c1) <= 80 * longint'(c0)) begin
      d = longint'(K0_BAND2) * c0 - longint'(K1_BAND2) * c1;
      r.status = ST_BAND2;
    end else if (100 * longint'(c1) <= 130 * longint'(c0)) begin
      d = longint'(K0_BAND3) * c0 - longint'(K1_BAND3) * c1;
      r.status = ST_BAND3;
    end else begin
      r.status = ST_RANGE;
      return r;
    end
    if (d < 0) d = 0;
    lux = longint'(d) * scale;
    if (!gain_is_high) lux = lux << 4;
    lux = lux >> (40 - LUX_FRAC_BITS_DEF);
    if (lux > LUX_MAX) lux = LUX_MAX;
    r.lux_value = lux[27:0];
    return r;
  endfunction

  task automatic send_beat(logic [15:0] c0, logic [15:0] c1);
    @(negedge clk);
    start <= 1'b1;
    in_data <= '{broadband_count: c0, infrared_count: c1};
    do @(posedge clk); while (busy);
    lux_expected_q.push_back(compute_lux(c0, c1));
    beats_sent++;
  endtask

  task automatic pause_input(int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [1:0] val);
    pause_input(0);
    while (lux_expected_q.size() != 0) @(negedge clk);
    repeat (PIPE_DRAIN) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_INT_TIME) int_time_sel = val;
    else if (idx == REG_GAIN) gain_is_high = val[0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    alc_out_t exp_r;
    if (rst_n && out_strobe) begin
      results_seen++;
      if (lux_expected_q.size() == 0) begin
        $error("unexpected result %h", out_data);
        fail_count++;
      end else begin
        exp_r = lux_expected_q.pop_front();
        status_hits[exp_r.status]++;
        if (out_data.lux_value !== exp_r.lux_value) begin
          $error("lux_value expected %0d actual %0d", exp_r.lux_value, out_data.lux_value);
          fail_count++;
        end
        if (out_data.ratio_q16 !== exp_r.ratio_q16) begin
          $error("ratio_q16 expected %0d actual %0d", exp_r.ratio_q16, out_data.ratio_q16);
          fail_count++;
        end
        if (out_data.status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_data.status);
          fail_count++;
        end
      end
    end
  end

  task automatic test_special_cases();
    send_beat(16'd0, 16'd0);
    send_beat(16'd0, 16'd1);
    send_beat(16'd0, 16'hFFFF);
    send_beat(16'hFFFF, 16'd0);
    send_beat(16'd0, 16'hFFFF);
    send_beat(16'hFFFE, 16'hFFFE);
    send_beat(16'hFFFE, 16'd0);
    send_beat(16'd1, 16'hFFFE);
    send_beat(16'd1, 16'd1);
    send_beat(16'd1000, 16'd0);
  endtask

  task automatic test_band_edges();
    send_beat(16'd100, 16'd52);
    send_beat(16'd100, 16'd53);
    send_beat(16'd100, 16'd65);
    send_beat(16'd100, 16'd66);
    send_beat(16'd100, 16'd80);
    send_beat(16'd100, 16'd81);
    send_beat(16'd100, 16'd130);
    send_beat(16'd100, 16'd131);
    send_beat(16'd60000, 16'd1);
  endtask

  task automatic test_limits();
    write_reg(REG_INT_TIME, IT_13MS);
    send_beat(16'd5046, 16'd100);
    send_beat(16'd5047, 16'd100);
    send_beat(16'd100, 16'd5047);
    write_reg(REG_INT_TIME, IT_101MS);
    send_beat(16'd37176, 16'd37176);
    send_beat(16'd37177, 16'd0);
    write_reg(REG_INT_TIME, 2'd3);
    send_beat(16'd65534, 16'd1000);
  endtask

  task automatic random_burst(int n);
    logic [15:0] c0;
    logic [15:0] c1;
    int sent;
    int burst;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && sent < n; b++) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            c0 = 16'($urandom);
            c1 = 16'($urandom);
          end
          2: begin
            c0 = 16'($urandom_range(0, 3));
            c1 = 16'($urandom_range(0, 3));
          end
          3: begin
            c0 = 16'($urandom_range(5040, 5050));
            c1 = 16'($urandom_range(0, 5050));
          end
          4: begin
            c0 = 16'($urandom_range(37170, 37180));
            c1 = 16'($urandom_range(65530, 65535));
          end
          default: begin
            c0 = 16'($urandom_range(1, 5046));
            if ($urandom_range(0, 1)) c0 = 16'($urandom_range(1, 65534));
            c1 = 16'((longint'(c0) * $urandom_range(0, 140)) / 100);
          end
        endcase
        send_beat(c0, c1);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause_input($urandom_range(1, 8));
    end
  endtask

  task automatic test_random_sweep();
    for (int it = 0; it < 4; it++) begin
      for (int g = 0; g < 2; g++) begin
        write_reg(REG_INT_TIME, 2'(it));
        write_reg(REG_GAIN, 2'(g));
        random_burst(110);
      end
    end
    write_reg(8'd7, 2'd1);
    write_reg(REG_GAIN, 2'd2);
    random_burst(30);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    int_time_sel = 2'd2;
    gain_is_high = 1'b0;
    fail_count = 0;
    beats_sent = 0;
    results_seen = 0;
    for (int s = 0; s < 8; s++) status_hits[s] = 0;
    fill_pow_lut();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_special_cases();
    test_band_edges();
    test_limits();
    test_random_sweep();
    pause_input(0);
    while (lux_expected_q.size() != 0) @(negedge clk);
    repeat (PIPE_DRAIN) @(negedge clk);
    $display("Sent %0d beats over all integration and gain settings; %0d results checked.",
             beats_sent, results_seen);
    $display("Band hits 0..3: %0d %0d %0d %0d, range %0d, saturated %0d, dark %0d.",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4], status_hits[5], status_hits[6]);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2400000;
    $display("status: fail");
    $finish;
  end

endmodule
